### hdl/mwo_pkg.sv
// Shared types and constants for the multi-waveform oscillator.
// Used by the front, the queue, the back and the top level; no dependencies.
package mwo_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = TBL_AW + 1;
  localparam int PHASE_W     = 32;
  localparam int SAMPLE_W    = 16;
  localparam int PW_W        = 16;
  localparam int CFG_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [PW_W-1:0]  PW_MIN      = 16'd655;
  localparam logic [PW_W-1:0]  PW_MAX      = 16'd64880;
  localparam logic [PW_W-1:0]  PW_RESET    = 16'd32768;
  localparam logic [LEN_W-1:0] LEN_MIN     = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    CFG_PHASE_INC   = 2'd0,
    CFG_WAVEFORM    = 2'd1,
    CFG_PULSE_WIDTH = 2'd2,
    CFG_TABLE_LEN   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAVE_SAW   = 2'd0,
    WAVE_TRI   = 2'd1,
    WAVE_PULSE = 2'd2,
    WAVE_TABLE = 2'd3
  } wave_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MULT,
    BK_FETCH,
    BK_LERP,
    BK_SUM
  } back_state_t;

  typedef struct packed {
    req_t                kind;
    logic [PHASE_W-1:0]  phase;
    logic [TBL_AW-1:0]   addr;
    logic [SAMPLE_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    wave_t             waveform;
    logic [PW_W-1:0]   pulse_width;
    logic [LEN_W-1:0]  table_length;
  } osc_cfg_t;

endpackage

### hdl/mwo_front.sv
// Front end: accepts input beats, advances the phase on ticks and queues work.
// Depends on mwo_pkg.
module mwo_front import mwo_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [TBL_AW-1:0]   in_table_index,
  input  logic [SAMPLE_W-1:0] in_table_value,
  input  logic [PHASE_W-1:0]  phase_increment,
  input  q_stat_t             q_stat,
  output logic                push,
  output q_entry_t            push_entry
);

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [PHASE_W-1:0] phase_sum;
  logic               accept;
  req_t               kind;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;
  assign kind      = req_t'(in_req_type);
  assign phase_sum = phase_r + phase_increment;
  assign push      = accept;

  always_comb begin
    phase_nxt = phase_r;
    if (accept && kind == REQ_TICK) begin
      phase_nxt = phase_sum;
    end
  end

  always_comb begin
    push_entry.kind  = kind;
    push_entry.phase = phase_sum;
    push_entry.addr  = in_table_index;
    push_entry.value = in_table_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

### hdl/mwo_queue.sv
// Short FIFO of work beats between the front and the back.
// Depends on mwo_pkg.
module mwo_queue import mwo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  q_entry_t        slots [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW-1:0] rd_ptr_nxt;
  logic [Q_AW:0]   count_r;
  logic [Q_AW:0]   count_nxt;

  assign head         = slots[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == (Q_AW+1)'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/mwo_back.sv
// Back end: wave generators, wavetable memory with interpolation, output register.
// Depends on mwo_pkg.
module mwo_back import mwo_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  osc_cfg_t            cfg,
  input  q_entry_t            head,
  input  q_stat_t             q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_sample
);

  function automatic logic [SAMPLE_W-1:0] gen_saw(input logic [PHASE_W-1:0] ph);
    return ph[PHASE_W-1 -: SAMPLE_W] ^ 16'h8000;
  endfunction

  function automatic logic [SAMPLE_W-1:0] gen_tri(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W:0]          d;
    logic signed [PHASE_W+1:0] v;
    logic signed [PHASE_W+1:0] q;
    d = {ph, 1'b0};
    if (d > {1'b1, {PHASE_W{1'b0}}}) begin
      d = -d;
    end
    v = $signed({1'b0, d}) - $signed((PHASE_W+2)'(34'h0_8000_0000));
    q = v >>> 16;
    if (v[PHASE_W+1] && (v[15:0] != '0)) begin
      q = q + 1'b1;
    end
    if (q > $signed((PHASE_W+2)'(32767))) begin
      q = (PHASE_W+2)'(32767);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] gen_pulse(input logic [PHASE_W-1:0] ph,
                                                     input logic [PW_W-1:0]    pw);
    logic [PW_W-1:0] w;
    w = pw;
    if (w < PW_MIN) begin
      w = PW_MIN;
    end
    if (w > PW_MAX) begin
      w = PW_MAX;
    end
    return (ph[PHASE_W-1 -: SAMPLE_W] < w) ? 16'h7FFF : 16'h8000;
  endfunction

  logic [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];

  back_state_t state_r;
  back_state_t state_nxt;

  logic [PHASE_W-1:0]       phase_r;
  logic [PHASE_W+LEN_W-1:0] t_r;
  logic [SAMPLE_W-1:0]      s0_r;
  logic [SAMPLE_W-1:0]      s1_r;
  logic [SAMPLE_W-1:0]      frac_r;
  logic signed [33:0]       prod_r;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [SAMPLE_W-1:0]      out_sample_r;

  logic                     out_free;
  logic                     is_table;
  logic                     start_table;
  logic                     wr_en;
  logic                     emit_simple;
  logic                     emit_table;
  logic [LEN_W-1:0]         len_eff;
  logic [TBL_AW-1:0]        idx;
  logic [LEN_W-1:0]         idx_inc;
  logic [TBL_AW-1:0]        nxt_idx;
  logic signed [16:0]       diff;
  logic signed [33:0]       acc;
  logic signed [33:0]       quo;
  logic [SAMPLE_W-1:0]      simple_sample;

  assign out_free = !out_valid_r || !out_stall;
  assign is_table = (cfg.waveform == WAVE_TABLE);

  always_comb begin
    len_eff = cfg.table_length;
    if (len_eff < LEN_MIN) begin
      len_eff = LEN_MIN;
    end
    if (len_eff > LEN_MAX) begin
      len_eff = LEN_MAX;
    end
  end

  assign idx     = t_r[PHASE_W +: TBL_AW];
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign nxt_idx = (idx_inc >= len_eff) ? '0 : idx_inc[TBL_AW-1:0];

  assign diff = $signed({s1_r[SAMPLE_W-1], s1_r}) - $signed({s0_r[SAMPLE_W-1], s0_r});

  always_comb begin
    acc = $signed({{2{s0_r[SAMPLE_W-1]}}, s0_r, 16'h0000}) + prod_r;
    quo = acc >>> 16;
    if (acc[33] && (acc[15:0] != '0)) begin
      quo = quo + 1'b1;
    end
  end

  always_comb begin
    unique case (cfg.waveform)
      WAVE_SAW:   simple_sample = gen_saw(head.phase);
      WAVE_TRI:   simple_sample = gen_tri(head.phase);
      WAVE_PULSE: simple_sample = gen_pulse(head.phase, cfg.pulse_width);
      WAVE_TABLE: simple_sample = '0;
      default:    simple_sample = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (start_table) state_nxt = BK_MULT;
      BK_MULT:  state_nxt = BK_FETCH;
      BK_FETCH: state_nxt = BK_LERP;
      BK_LERP:  state_nxt = BK_SUM;
      BK_SUM:   if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    wr_en       = 1'b0;
    start_table = 1'b0;
    emit_simple = 1'b0;
    emit_table  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          if (head.kind == REQ_LOAD) begin
            pop   = 1'b1;
            wr_en = 1'b1;
          end else if (is_table) begin
            pop         = 1'b1;
            start_table = 1'b1;
          end else if (out_free) begin
            pop         = 1'b1;
            emit_simple = 1'b1;
          end
        end
      end
      BK_SUM:  emit_table = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit_simple || emit_table) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_table) begin
      phase_r <= head.phase;
    end
    if (state_r == BK_MULT) begin
      t_r <= len_eff * phase_r;
    end
    if (state_r == BK_FETCH) begin
      frac_r <= t_r[PHASE_W-1 -: SAMPLE_W];
    end
    if (state_r == BK_LERP) begin
      prod_r <= diff * $signed({1'b0, frac_r});
    end
    if (emit_simple) begin
      out_sample_r <= simple_sample;
    end else if (emit_table) begin
      out_sample_r <= quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem[head.addr] <= head.value;
    end
    if (state_r == BK_FETCH) begin
      s0_r <= wave_mem[idx];
      s1_r <= wave_mem[nxt_idx];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

### hdl/multi_waveform_oscillator_unit.sv
// Top level of the multi-waveform oscillator: configuration registers, front, queue, back.
// Depends on mwo_pkg, mwo_front, mwo_queue and mwo_back.
//
// Direct digital synthesis oscillator with a 32-bit phase accumulator. Each tick beat
// adds phase_increment to the phase and yields one signed 16-bit sample (sawtooth,
// triangle, pulse or interpolated wavetable); a load beat writes one wavetable entry
// and yields nothing. The front takes one beat per cycle while the queue is not full
// into a four-beat queue. The back handles a load beat or a sawtooth, triangle or
// pulse tick straight from its idle state, and a wavetable tick in the steps length
// multiply, two-port table read, interpolation multiply and sum; it takes no new beat
// from the queue until that sum has been emitted. The wavetable has no reset; read
// only entries already loaded. Write configuration only while the block is idle.
module multi_waveform_oscillator_unit import mwo_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [TBL_AW-1:0]   in_table_index,
  input  logic [SAMPLE_W-1:0] in_table_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_sample,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  logic [PHASE_W-1:0] phase_inc_r;
  wave_t              waveform_r;
  logic [PW_W-1:0]    pulse_width_r;
  logic [LEN_W-1:0]   table_len_r;

  osc_cfg_t osc_cfg;
  q_entry_t push_entry;
  q_entry_t head;
  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r   <= '0;
      waveform_r    <= WAVE_SAW;
      pulse_width_r <= PW_RESET;
      table_len_r   <= LEN_MAX;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PHASE_INC:   phase_inc_r   <= cfg_wdata[PHASE_W-1:0];
        CFG_WAVEFORM:    waveform_r    <= wave_t'(cfg_wdata[1:0]);
        CFG_PULSE_WIDTH: pulse_width_r <= cfg_wdata[PW_W-1:0];
        CFG_TABLE_LEN:   table_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    osc_cfg.waveform     = waveform_r;
    osc_cfg.pulse_width  = pulse_width_r;
    osc_cfg.table_length = table_len_r;
  end

  mwo_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .phase_increment (phase_inc_r),
    .q_stat          (q_stat),
    .push            (q_push),
    .push_entry      (push_entry)
  );

  mwo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mwo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (osc_cfg),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (q_stat.empty && !out_valid))
    else $error("queue or output not cleared by reset");

endmodule
